// File: hdl/slpa_pkg.sv
// shared constants and types of the sample loop playback addresser
// no dependencies; used by the top level and its port checker

package slpa_pkg;

	localparam int MAX_LOOPS = 8;

	localparam int POS_W    = 32;                      // byte positions and offsets
	localparam int FRAME_W  = 32;                      // frame numbers
	localparam int CNT_W    = 32;                      // loop play counts
	localparam int LEN_W    = 16;                      // request and read lengths
	localparam int BPF_W    = 5;                       // bytes per frame
	localparam int BYTE_W   = 38;                      // loop bounds in bytes, no wrap
	localparam int LOADED_W = $clog2(MAX_LOOPS + 1);   // fill count of the loop table
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int CMD_W      = 2;

	localparam logic [BPF_W-1:0] BPF_RESET = BPF_W'(4);

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD  = 2'd0,
		CMD_PLAY  = 2'd1,
		CMD_FETCH = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DATA_START      = 2'd0,
		REG_DATA_END        = 2'd1,
		REG_BYTES_PER_FRAME = 2'd2
	} cfg_reg_t;

endpackage

// File: hdl/sample_loop_playback_addresser_top.sv
// sample loop playback addresser, top level
// depends on slpa_pkg for widths, the loop table depth and command codes

// Keeps a byte read position inside a block of sample data and a table of up to
// slpa_pkg::MAX_LOOPS forward loops. A load request appends a loop (table_full
// when the table is already full), a play request moves the position to
// data_start and arms every loaded loop with its play count, and a fetch request
// returns the read address and the request length clamped to the current stop,
// then advances the position and jumps back, counts down or retires the loop at
// its end. Every request gives exactly one result. Rate: one request per clock
// while item_stall is low; a request is registered, then passes once through the
// loop compare bank, the clamp and the position update into the result register.
// Loop byte bounds are kept precomputed in registers from the stored frame
// numbers and the configuration, so the item channel stalls in each cycle in
// which a configuration write lands. The configuration port is always ready;
// the user must write only while no request is outstanding; not enforced here.

module sample_loop_playback_addresser_top (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [slpa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [slpa_pkg::CFG_DATA_W-1:0]    cfg_data,
	// request channel
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic [slpa_pkg::CMD_W-1:0]         command,
	input  logic [slpa_pkg::FRAME_W-1:0]       loop_start_frame,
	input  logic [slpa_pkg::FRAME_W-1:0]       loop_end_frame,
	input  logic [slpa_pkg::CNT_W-1:0]         loop_play_count,
	input  logic [slpa_pkg::LEN_W-1:0]         request_len,
	// result channel
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [slpa_pkg::POS_W-1:0]         read_addr,
	output logic [slpa_pkg::LEN_W-1:0]         read_len,
	output logic                               jumped_back,
	output logic                               loop_finished,
	output logic                               at_end,
	output logic                               table_full
);

	localparam int NL = slpa_pkg::MAX_LOOPS;
	localparam int PW = slpa_pkg::POS_W;
	localparam int BW = slpa_pkg::BYTE_W;

	// configuration registers
	logic [PW-1:0]                  data_start_q;
	logic [PW-1:0]                  data_end_q;
	logic [slpa_pkg::BPF_W-1:0]     bpf_q;
	logic                           cfg_wr;

	// input stage
	logic                           valid_s1;
	slpa_pkg::cmd_t                 cmd_s1;
	logic [slpa_pkg::FRAME_W-1:0]   start_frame_s1;
	logic [slpa_pkg::FRAME_W-1:0]   end_frame_s1;
	logic [slpa_pkg::CNT_W-1:0]     count_s1;
	logic [slpa_pkg::LEN_W-1:0]     req_len_s1;

	// block state
	logic [PW-1:0]                  pos_q;
	logic [slpa_pkg::LOADED_W-1:0]  loaded_q;
	logic [NL-1:0]                  active_q;
	logic [slpa_pkg::FRAME_W-1:0]   start_frame_q [NL];
	logic [slpa_pkg::FRAME_W-1:0]   end_frame_q   [NL];
	logic [slpa_pkg::CNT_W-1:0]     init_cnt_q    [NL];
	logic [slpa_pkg::CNT_W-1:0]     rem_cnt_q     [NL];
	logic [BW-1:0]                  start_byte_q  [NL];
	logic [BW-1:0]                  stop_byte_q   [NL];

	// flow control
	logic                           out_free;
	logic                           advance;
	logic                           item_take;

	// single pass logic
	logic [NL-1:0]                  in_range;
	logic [NL-1:0]                  hit_oh;
	logic                           found;
	logic [BW-1:0]                  pos_ext;
	logic [BW-1:0]                  sel_stop;
	logic [BW-1:0]                  sel_start;
	logic [slpa_pkg::CNT_W-1:0]     sel_cnt;
	logic [BW-1:0]                  avail;
	logic [slpa_pkg::LEN_W-1:0]     clamp_len;
	logic [PW:0]                    sum;
	logic [PW-1:0]                  adv_pos;
	logic                           wrap;
	logic                           cnt_one;
	logic                           tbl_full;

	logic [PW-1:0]                  nxt_addr;
	logic [slpa_pkg::LEN_W-1:0]     nxt_len;
	logic                           nxt_jump;
	logic                           nxt_fin;
	logic                           nxt_full;
	logic [PW-1:0]                  nxt_pos;

	// configuration port never pushes back; a landing write holds off one request
	// so the loop byte bounds are rebuilt before the next fetch looks at them
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_start_q <= '0;
			data_end_q   <= '0;
			bpf_q        <= slpa_pkg::BPF_RESET;
		end else if (cfg_wr) begin
			case (slpa_pkg::cfg_reg_t'(cfg_index))
				slpa_pkg::REG_DATA_START:      data_start_q <= cfg_data[PW-1:0];
				slpa_pkg::REG_DATA_END:        data_end_q   <= cfg_data[PW-1:0];
				slpa_pkg::REG_BYTES_PER_FRAME: bpf_q        <= cfg_data[slpa_pkg::BPF_W-1:0];
				default: ;  // writes past the register list are dropped
			endcase
		end
	end

	// the result register parts the two sides; the input stage moves on whenever
	// the result register is empty or being drained
	assign out_free   = !result_valid || !result_stall;
	assign advance    = valid_s1 && out_free;
	assign item_stall = (valid_s1 && !out_free) || cfg_wr;
	assign item_take  = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			cmd_s1         <= slpa_pkg::cmd_t'(command);
			start_frame_s1 <= loop_start_frame;
			end_frame_s1   <= loop_end_frame;
			count_s1       <= loop_play_count;
			req_len_s1     <= request_len;
		end
	end

	// loop byte bounds, rebuilt every cycle from frames and configuration:
	// start = data_start + start_frame * bpf, stop = data_start + (end_frame + 1) * bpf
	always_ff @(posedge clk) begin
		for (int i = 0; i < NL; i++) begin
			start_byte_q[i] <= {{(BW-PW){1'b0}}, data_start_q}
				+ {{(BW-slpa_pkg::FRAME_W){1'b0}}, start_frame_q[i]}
				* {{(BW-slpa_pkg::BPF_W){1'b0}}, bpf_q};
			stop_byte_q[i]  <= {{(BW-PW){1'b0}}, data_start_q}
				+ ({{(BW-slpa_pkg::FRAME_W){1'b0}}, end_frame_q[i]} + BW'(1))
				* {{(BW-slpa_pkg::BPF_W){1'b0}}, bpf_q};
		end
	end

	// first active loop holding the position wins
	always_comb begin
		pos_ext   = {{(BW-PW){1'b0}}, pos_q};
		found     = 1'b0;
		sel_stop  = '0;
		sel_start = '0;
		sel_cnt   = '0;
		for (int i = 0; i < NL; i++) begin
			in_range[i] = active_q[i] && (pos_ext >= start_byte_q[i])
				&& (pos_ext < stop_byte_q[i]);
			hit_oh[i]   = in_range[i] && !found;
			found       = found | in_range[i];
			sel_stop    = sel_stop  | (stop_byte_q[i]  & {BW{hit_oh[i]}});
			sel_start   = sel_start | (start_byte_q[i] & {BW{hit_oh[i]}});
			sel_cnt     = sel_cnt   | (rem_cnt_q[i] & {slpa_pkg::CNT_W{hit_oh[i]}});
		end
		if (!found) begin
			sel_stop = {{(BW-PW){1'b0}}, data_end_q};
		end
	end

	// clamp to the stop, advance with saturation, check for the loop end
	always_comb begin
		avail = sel_stop - pos_ext;
		if (sel_stop <= pos_ext) begin
			clamp_len = '0;
		end else if (avail < {{(BW-slpa_pkg::LEN_W){1'b0}}, req_len_s1}) begin
			clamp_len = avail[slpa_pkg::LEN_W-1:0];
		end else begin
			clamp_len = req_len_s1;
		end
		sum     = {1'b0, pos_q} + {{(PW+1-slpa_pkg::LEN_W){1'b0}}, clamp_len};
		adv_pos = sum[PW] ? {PW{1'b1}} : sum[PW-1:0];
		wrap    = found && ({{(BW-PW){1'b0}}, adv_pos} >= sel_stop);
		cnt_one = (sel_cnt == slpa_pkg::CNT_W'(1));
	end

	assign tbl_full = (loaded_q >= slpa_pkg::LOADED_W'(NL));

	always_comb begin
		nxt_addr = '0;
		nxt_len  = '0;
		nxt_jump = 1'b0;
		nxt_fin  = 1'b0;
		nxt_full = 1'b0;
		nxt_pos  = pos_q;
		case (cmd_s1)
			slpa_pkg::CMD_LOAD: begin
				nxt_full = tbl_full;
			end
			slpa_pkg::CMD_PLAY: begin
				nxt_pos = data_start_q;
			end
			slpa_pkg::CMD_FETCH: begin
				nxt_addr = pos_q;
				nxt_len  = clamp_len;
				nxt_fin  = wrap && cnt_one;
				nxt_jump = wrap && !cnt_one;
				// loop start lies at or below the position, so it fits the position width
				nxt_pos  = nxt_jump ? sel_start[PW-1:0] : adv_pos;
			end
			default: ;  // unused code: nothing moves
		endcase
	end

	// control state: position, fill count, active marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			loaded_q <= '0;
			active_q <= '0;
		end else if (advance) begin
			pos_q <= nxt_pos;
			case (cmd_s1)
				slpa_pkg::CMD_LOAD: begin
					if (!tbl_full) begin
						loaded_q <= loaded_q + slpa_pkg::LOADED_W'(1);
						for (int i = 0; i < NL; i++) begin
							if (loaded_q == slpa_pkg::LOADED_W'(i)) begin
								active_q[i] <= 1'b0;
							end
						end
					end
				end
				slpa_pkg::CMD_PLAY: begin
					for (int i = 0; i < NL; i++) begin
						if (slpa_pkg::LOADED_W'(i) < loaded_q) begin
							active_q[i] <= 1'b1;
						end
					end
				end
				slpa_pkg::CMD_FETCH: begin
					for (int i = 0; i < NL; i++) begin
						if (hit_oh[i] && nxt_fin) begin
							active_q[i] <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// loop table contents, valid only below the fill count
	always_ff @(posedge clk) begin
		if (advance) begin
			case (cmd_s1)
				slpa_pkg::CMD_LOAD: begin
					for (int i = 0; i < NL; i++) begin
						if (!tbl_full && loaded_q == slpa_pkg::LOADED_W'(i)) begin
							start_frame_q[i] <= start_frame_s1;
							end_frame_q[i]   <= end_frame_s1;
							init_cnt_q[i]    <= count_s1;
							rem_cnt_q[i]     <= count_s1;
						end
					end
				end
				slpa_pkg::CMD_PLAY: begin
					for (int i = 0; i < NL; i++) begin
						if (slpa_pkg::LOADED_W'(i) < loaded_q) begin
							rem_cnt_q[i] <= init_cnt_q[i];
						end
					end
				end
				slpa_pkg::CMD_FETCH: begin
					// a zero count loops forever and is never decremented
					for (int i = 0; i < NL; i++) begin
						if (hit_oh[i] && nxt_jump && rem_cnt_q[i] != '0) begin
							rem_cnt_q[i] <= rem_cnt_q[i] - slpa_pkg::CNT_W'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_free) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_addr     <= nxt_addr;
			read_len      <= nxt_len;
			jumped_back   <= nxt_jump;
			loop_finished <= nxt_fin;
			table_full    <= nxt_full;
			at_end        <= (nxt_pos >= data_end_q);
		end
	end

endmodule

// File: hdl/slpa_checker.sv
// port level checks of the sample loop playback addresser, and their bind
// depends on slpa_pkg for port widths

module slpa_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               cfg_valid,
	input logic                               cfg_ready,
	input logic [slpa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input logic [slpa_pkg::CFG_DATA_W-1:0]    cfg_data,
	input logic                               item_valid,
	input logic                               item_stall,
	input logic [slpa_pkg::CMD_W-1:0]         command,
	input logic [slpa_pkg::FRAME_W-1:0]       loop_start_frame,
	input logic [slpa_pkg::FRAME_W-1:0]       loop_end_frame,
	input logic [slpa_pkg::CNT_W-1:0]         loop_play_count,
	input logic [slpa_pkg::LEN_W-1:0]         request_len,
	input logic                               result_valid,
	input logic                               result_stall,
	input logic [slpa_pkg::POS_W-1:0]         read_addr,
	input logic [slpa_pkg::LEN_W-1:0]         read_len,
	input logic                               jumped_back,
	input logic                               loop_finished,
	input logic                               at_end,
	input logic                               table_full
);

	// a landing configuration write never coincides with a taken request
	a_cfg_holds_items: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |-> item_stall)
		else $error("request taken in the cycle of a configuration write");

	// a loop end event only follows a fetch that moved the position
	a_loop_event_len: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (jumped_back || loop_finished)) |-> (read_len != '0))
		else $error("loop end reported on an empty read");

	// one loop end event per result: jump back or retire, not both
	a_event_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(jumped_back && loop_finished))
		else $error("jump back and loop finish in one result");

	// a rejected load carries no read and no loop event
	a_full_is_load: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && table_full) |->
			(read_addr == '0 && read_len == '0 && !jumped_back && !loop_finished))
		else $error("table full flag on a result that is not a load");

	// a stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=>
			(result_valid && $stable(read_addr) && $stable(read_len) && $stable(at_end)))
		else $error("stalled result changed");

endmodule

bind sample_loop_playback_addresser_top slpa_checker u_slpa_checker (.*);

// File: tb/testbench.sv
// self-checking testbench of the sample loop playback addresser
// sends load, play and fetch requests and register writes, then checks each result
// against a predictor kept in the bench; depends on slpa_pkg and the top level

module testbench;
	import slpa_pkg::*;

	localparam logic [CMD_W-1:0]     CMD_SPARE = 2'd3;      // command code with no effect
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;      // register index with no effect
	localparam int STALL_LIMIT     = 4000;                  // cycles without any handshake
	localparam int REQS_PER_PHASE  = 88;                    // play and fetch requests per phase
	localparam int PHASES_PER_MODE = 4;

	// one result item, in port order
	typedef struct packed {
		logic [POS_W-1:0] addr;
		logic [LEN_W-1:0] len;
		logic             jumped;
		logic             finished;
		logic             at_end;
		logic             full;
	} chunk_t;

	// one line of the directed script: a request or a register write
	typedef struct packed {
		logic                  is_write;
		logic [CMD_W-1:0]      cmd;
		logic [FRAME_W-1:0]    first_frame;
		logic [FRAME_W-1:0]    last_frame;
		logic [CNT_W-1:0]      passes;
		logic [LEN_W-1:0]      want;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		logic                  known;   // result typed in by hand
		chunk_t                result;
	} script_row_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  item_valid = 1'b0;
	logic                  item_stall;
	logic [CMD_W-1:0]      command = CMD_LOAD;
	logic [FRAME_W-1:0]    loop_start_frame = '0;
	logic [FRAME_W-1:0]    loop_end_frame = '0;
	logic [CNT_W-1:0]      loop_play_count = '0;
	logic [LEN_W-1:0]      request_len = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic [POS_W-1:0]      read_addr;
	logic [LEN_W-1:0]      read_len;
	logic                  jumped_back;
	logic                  loop_finished;
	logic                  at_end;
	logic                  table_full;

	// predictor state: playhead, loop table and the current register values
	logic [POS_W-1:0]   play_pos = '0;
	logic [FRAME_W-1:0] loop_first [MAX_LOOPS];
	logic [FRAME_W-1:0] loop_last [MAX_LOOPS];
	logic [CNT_W-1:0]   loop_passes [MAX_LOOPS];
	logic [CNT_W-1:0]   loop_left [MAX_LOOPS];
	logic               loop_armed [MAX_LOOPS];
	int                 loops_held = 0;
	logic [POS_W-1:0]   cur_data_start = '0;
	logic [POS_W-1:0]   cur_data_end = '0;
	logic [BPF_W-1:0]   cur_frame_bytes = BPF_RESET;

	chunk_t pending_chunks [$];   // predicted results still to come out, oldest first
	int     mismatches = 0;
	int     idle_cycles = 0;
	int     tx_idle_pct = 17;     // chance in percent that the sender idles a cycle
	int     rx_idle_pct = 56;     // chance in percent that the receiver stalls a cycle

	sample_loop_playback_addresser_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.item_valid(item_valid), .item_stall(item_stall), .command(command),
		.loop_start_frame(loop_start_frame), .loop_end_frame(loop_end_frame),
		.loop_play_count(loop_play_count), .request_len(request_len),
		.result_valid(result_valid), .result_stall(result_stall),
		.read_addr(read_addr), .read_len(read_len), .jumped_back(jumped_back),
		.loop_finished(loop_finished), .at_end(at_end), .table_full(table_full)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// walks one request through the playhead and loop table, gives the result it causes
	task automatic compute_chunk(input logic [CMD_W-1:0] cmd, input logic [FRAME_W-1:0] first_frame,
			input logic [FRAME_W-1:0] last_frame, input logic [CNT_W-1:0] passes,
			input logic [LEN_W-1:0] want, output chunk_t r);
		logic [BYTE_W-1:0] pos, stop, lo, hi, take, after_pos, loop_lo;
		int hit;
		r = '0;
		case (cmd)
			CMD_LOAD: begin
				// a full table turns the load away, otherwise it lands unarmed
				if (loops_held >= MAX_LOOPS) begin
					r.full = 1'b1;
				end else begin
					loop_first[loops_held]  = first_frame;
					loop_last[loops_held]   = last_frame;
					loop_passes[loops_held] = passes;
					loop_left[loops_held]   = passes;
					loop_armed[loops_held]  = 1'b0;
					loops_held++;
				end
			end
			CMD_PLAY: begin
				for (int i = 0; i < loops_held; i++) begin
					loop_armed[i] = 1'b1;
					loop_left[i]  = loop_passes[i];
				end
				play_pos = cur_data_start;
			end
			CMD_FETCH: begin
				pos     = BYTE_W'(play_pos);
				stop    = BYTE_W'(cur_data_end);
				take    = BYTE_W'(want);
				loop_lo = '0;
				hit     = -1;
				// first armed loop holding the playhead wins; bounds never wrap
				for (int i = 0; i < loops_held; i++) begin
					lo = BYTE_W'(cur_data_start) + BYTE_W'(loop_first[i]) * BYTE_W'(cur_frame_bytes);
					hi = BYTE_W'(cur_data_start)
						+ (BYTE_W'(loop_last[i]) + BYTE_W'(1)) * BYTE_W'(cur_frame_bytes);
					if (hit < 0 && loop_armed[i] && pos >= lo && pos < hi) begin
						hit     = i;
						loop_lo = lo;
						stop    = hi;
					end
				end
				if (stop <= pos)
					take = '0;
				else if (stop - pos < take)
					take = stop - pos;
				r.addr = play_pos;
				r.len  = take[LEN_W-1:0];
				// playhead saturates at the top of the byte space
				after_pos = pos + take;
				if (after_pos > BYTE_W'(32'hFFFF_FFFF))
					after_pos = BYTE_W'(32'hFFFF_FFFF);
				play_pos = after_pos[POS_W-1:0];
				if (hit >= 0 && after_pos >= stop) begin
					if (loop_left[hit] == CNT_W'(1)) begin
						loop_armed[hit] = 1'b0;
						r.finished      = 1'b1;
					end else begin
						// zero passes loops forever, anything else counts down
						if (loop_left[hit] != '0)
							loop_left[hit] = loop_left[hit] - CNT_W'(1);
						play_pos = loop_lo[POS_W-1:0];
						r.jumped = 1'b1;
					end
				end
			end
			default: ;   // spare code leaves the state alone
		endcase
		r.at_end = (play_pos >= cur_data_end);
	endtask

	function automatic script_row_t req(input logic [CMD_W-1:0] cmd,
			input logic [FRAME_W-1:0] first_frame, input logic [FRAME_W-1:0] last_frame,
			input logic [CNT_W-1:0] passes, input logic [LEN_W-1:0] want);
		script_row_t row = '0;
		row.cmd         = cmd;
		row.first_frame = first_frame;
		row.last_frame  = last_frame;
		row.passes      = passes;
		row.want        = want;
		return row;
	endfunction

	// request whose result is plain: only the at_end and table_full flags may be set
	function automatic script_row_t req_seen(input logic [CMD_W-1:0] cmd,
			input logic [FRAME_W-1:0] first_frame, input logic [FRAME_W-1:0] last_frame,
			input logic [CNT_W-1:0] passes, input logic [LEN_W-1:0] want,
			input logic end_flag, input logic full_flag);
		script_row_t row;
		row             = req(cmd, first_frame, last_frame, passes, want);
		row.known       = 1'b1;
		row.result      = '0;
		row.result.at_end = end_flag;
		row.result.full = full_flag;
		return row;
	endfunction

	function automatic script_row_t wr(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		script_row_t row = '0;
		row.is_write = 1'b1;
		row.reg_idx  = idx;
		row.reg_val  = val;
		return row;
	endfunction

	// one request: maybe idle first, hold until taken, then predict its result
	task automatic send_request(input script_row_t row);
		chunk_t predicted;
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
		end
		item_valid       <= 1'b1;
		command          <= row.cmd;
		loop_start_frame <= row.first_frame;
		loop_end_frame   <= row.last_frame;
		loop_play_count  <= row.passes;
		request_len      <= row.want;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		compute_chunk(row.cmd, row.first_frame, row.last_frame, row.passes, row.want, predicted);
		pending_chunks.push_back(row.known ? row.result : predicted);
	endtask

	// register write; valid stays up when another write follows right away
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val,
			input bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_DATA_START:      cur_data_start  = val;
			REG_DATA_END:        cur_data_end    = val;
			REG_BYTES_PER_FRAME: cur_frame_bytes = val[BPF_W-1:0];
			default: ;
		endcase
		if (last)
			cfg_valid <= 1'b0;
	endtask

	// stop sending, let every predicted result come out, then cover the pipeline depth
	task automatic wait_drained();
		item_valid <= 1'b0;
		while (pending_chunks.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic note_mismatch(input string field, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
	endtask

	// result side: random stall, then compare every taken result with the oldest prediction
	always @(posedge clk)
		result_stall <= ($urandom_range(0, 99) < rx_idle_pct);

	always @(posedge clk) begin
		chunk_t seen, due;
		if (result_valid && !result_stall) begin
			seen = {read_addr, read_len, jumped_back, loop_finished, at_end, table_full};
			if (pending_chunks.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with none predicted, addr %h len %h", $realtime,
						seen.addr, seen.len);
			end else begin
				due = pending_chunks.pop_front();
				if (seen.addr !== due.addr)
					note_mismatch("read_addr", due.addr, seen.addr);
				if (seen.len !== due.len)
					note_mismatch("read_len", 32'(due.len), 32'(seen.len));
				if (seen.jumped !== due.jumped)
					note_mismatch("jumped_back", 32'(due.jumped), 32'(seen.jumped));
				if (seen.finished !== due.finished)
					note_mismatch("loop_finished", 32'(due.finished), 32'(seen.finished));
				if (seen.at_end !== due.at_end)
					note_mismatch("at_end", 32'(due.at_end), 32'(seen.at_end));
				if (seen.full !== due.full)
					note_mismatch("table_full", 32'(due.full), 32'(seen.full));
			end
		end
	end

	// watchdog: any handshake on any channel counts as progress
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		script_row_t script [$];
		script_row_t row;
		logic [POS_W-1:0] base, span_end;
		logic [BPF_W-1:0] frame_bytes;
		int unsigned span;
		int pick;
		int served;
		for (int i = 0; i < MAX_LOOPS; i++) begin
			loop_first[i]  = '0;
			loop_last[i]   = '0;
			loop_passes[i] = '0;
			loop_left[i]   = '0;
			loop_armed[i]  = 1'b0;
		end

		// reset held low from the start, released on an edge
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// straight out of reset the data window is empty, so the playhead sits at the end
		script.push_back(req_seen(CMD_FETCH, '0, '0, '0, 16'hFFFF, 1'b1, 1'b0));
		script.push_back(req_seen(CMD_SPARE, '1, '1, '1, 16'hFFFF, 1'b1, 1'b0));
		script.push_back(req_seen(CMD_PLAY, '0, '0, '0, '0, 1'b1, 1'b0));
		script.push_back(wr(REG_DATA_END, 32'h0000_1000));
		script.push_back(wr(REG_SPARE, 32'hFFFF_FFFF));
		// fill the table; it keeps these loops for the whole run
		script.push_back(req_seen(CMD_LOAD, 32'd2, 32'd5, 32'd2, '0, 1'b0, 1'b0));
		script.push_back(req_seen(CMD_LOAD, 32'd8, 32'd9, 32'd1, '0, 1'b0, 1'b0));
		script.push_back(req_seen(CMD_LOAD, '1, '1, '1, '0, 1'b0, 1'b0));         // never reachable
		script.push_back(req_seen(CMD_LOAD, 32'd12, 32'd15, 32'd3, '0, 1'b0, 1'b0));
		script.push_back(req_seen(CMD_LOAD, 32'd20, 32'd19, 32'd2, '0, 1'b0, 1'b0)); // empty loop
		script.push_back(req_seen(CMD_LOAD, 32'd24, 32'd31, 32'd0, '0, 1'b0, 1'b0)); // forever
		script.push_back(req_seen(CMD_LOAD, 32'd0, 32'd0, 32'd1, '0, 1'b0, 1'b0));
		// top of the byte space, stop past 32 bits
		script.push_back(req_seen(CMD_LOAD, 32'h3FFF_FFC0, '1, 32'd0, '0, 1'b0, 1'b0));
		script.push_back(req_seen(CMD_LOAD, '0, '0, '0, '0, 1'b0, 1'b1));           // table full
		script.push_back(req_seen(CMD_PLAY, '0, '0, '0, '0, 1'b0, 1'b0));
		// zero length, single pass finish, counted jump back, clamp to data end
		script.push_back(req(CMD_FETCH, '0, '0, '0, 16'd0));
		script.push_back(req(CMD_FETCH, '0, '0, '0, 16'd100));
		script.push_back(req(CMD_FETCH, '0, '0, '0, 16'd4));
		script.push_back(req(CMD_FETCH, '0, '0, '0, 16'hFFFF));
		script.push_back(req(CMD_FETCH, '0, '0, '0, 16'd16));
		script.push_back(req(CMD_FETCH, '0, '0, '0, 16'hFFFF));
		// register writes leave the playhead alone: park it high, then fetch past the top
		script.push_back(wr(REG_DATA_START, 32'hFFFF_FF00));
		script.push_back(req(CMD_PLAY, '0, '0, '0, '0));
		script.push_back(wr(REG_DATA_START, 32'h0));
		script.push_back(req(CMD_FETCH, '0, '0, '0, 16'hFFFF));
		// zero byte frames make every loop empty
		script.push_back(wr(REG_BYTES_PER_FRAME, 32'd0));
		script.push_back(req(CMD_FETCH, '0, '0, '0, 16'd16));
		// widest frame with data start and end at the top
		script.push_back(wr(REG_DATA_END, 32'hFFFF_FFFF));
		script.push_back(wr(REG_BYTES_PER_FRAME, 32'd31));
		script.push_back(wr(REG_DATA_START, 32'hFFFF_FFFF));
		script.push_back(req(CMD_PLAY, '0, '0, '0, '0));
		script.push_back(req(CMD_FETCH, '0, '0, '0, 16'hFFFF));

		for (int k = 0; k < script.size(); k++) begin
			if (script[k].is_write) begin
				// writes only with nothing in flight
				if (k == 0 || !script[k-1].is_write)
					wait_drained();
				write_reg(script[k].reg_idx, script[k].reg_val,
					k + 1 == script.size() || !script[k+1].is_write);
			end else begin
				send_request(script[k]);
			end
		end

		// random part: three idling modes, each a few phases with fresh register values
		for (int mode = 0; mode < 3; mode++) begin
			tx_idle_pct = (mode == 0) ? 17 : (mode == 1) ? 56 : 0;
			rx_idle_pct = (mode == 0) ? 56 : (mode == 1) ? 17 : 0;
			for (int ph = 0; ph < PHASES_PER_MODE; ph++) begin
				// sender holds off until every result is out, then reprograms
				wait_drained();
				pick = $urandom_range(0, 9);
				base = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF :
					(pick == 2) ? 32'($urandom) : 32'($urandom_range(0, 2000));
				pick = $urandom_range(0, 9);
				span_end = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF :
					(pick == 2) ? 32'($urandom) : base + 32'($urandom_range(0, 800));
				pick = $urandom_range(0, 9);
				frame_bytes = (pick == 0) ? BPF_W'(0) : (pick == 1) ? BPF_W'(31) :
					(pick == 2) ? BPF_W'(1) : BPF_W'($urandom_range(1, 16));
				write_reg(REG_DATA_START, base, 1'b0);
				write_reg(REG_DATA_END, span_end, 1'b0);
				write_reg(REG_BYTES_PER_FRAME, CFG_DATA_W'(frame_bytes), 1'b1);

				// mostly a play followed by a run of fetches, with noise mixed in
				send_request(req(CMD_PLAY, $urandom, $urandom, $urandom, LEN_W'($urandom)));
				served = 1;
				while (served < REQS_PER_PHASE) begin
					pick = $urandom_range(0, 99);
					if (pick < 6) begin
						row = req(CMD_PLAY, $urandom, $urandom, $urandom, LEN_W'($urandom));
					end else if (pick < 10) begin
						// table stays full, so loads only raise table_full
						row = req(CMD_LOAD, $urandom, $urandom, $urandom, LEN_W'($urandom));
					end else if (pick < 13) begin
						row = req(CMD_SPARE, $urandom, $urandom, $urandom, LEN_W'($urandom));
					end else begin
						// lengths mostly around a few frames so loop ends are hit often
						pick = $urandom_range(0, 99);
						if (pick < 70)
							span = $urandom_range(0, 3 * int'(cur_frame_bytes) + 8);
						else if (pick < 85)
							span = $urandom_range(0, 64);
						else if (pick < 95)
							span = $urandom_range(0, 65535);
						else
							span = 65535;
						row = req(CMD_FETCH, $urandom, $urandom, $urandom, LEN_W'(span));
					end
					send_request(row);
					if (row.cmd == CMD_PLAY || row.cmd == CMD_FETCH)
						served++;
				end
			end
		end

		// everything sent: wait for the last results and a few quiet cycles
		wait_drained();
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
